// ----- hw/rtl/hsv2rgb_pkg.sv -----
// Shared types, constants and helper functions for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Width of one color channel; the channel full-scale value is 2^CHANNEL_BITS - 1.
  localparam int CHANNEL_BITS = 8;
  // Hue carries a 3-bit sector above an 8-bit fraction.
  localparam int HUE_BITS     = 11;
  localparam int FRAC_BITS    = 8;
  // Width of the 1 - s*f terms, scaled by CH_MAX * 2^FRAC_BITS.
  localparam int SCALE_BITS   = CHANNEL_BITS + FRAC_BITS;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX   = {CHANNEL_BITS{1'b1}};
  localparam logic [FRAC_BITS:0]      FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SCALE_BITS-1:0]   K_SCALE  = {CH_MAX, {FRAC_BITS{1'b0}}};

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // Hue sectors, named after the channel order that carries v, the rising
  // term and the falling term.
  typedef enum logic [2:0] {
    SEC_RED_RISE_G   = 3'd0,
    SEC_GREEN_FALL_R = 3'd1,
    SEC_GREEN_RISE_B = 3'd2,
    SEC_BLUE_FALL_G  = 3'd3,
    SEC_BLUE_RISE_R  = 3'd4,
    SEC_RED_FALL_B   = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    chan_t               saturation;
    chan_t               brightness;
  } hsv_in_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_out_t;

  // Floor division by CH_MAX for values whose quotient is at most CH_MAX:
  // q = (y + (y >> CHANNEL_BITS) + 1) >> CHANNEL_BITS.
  function automatic chan_t div_by_max(input logic [2*CHANNEL_BITS-1:0] y);
    logic [2*CHANNEL_BITS:0] sum;
    sum = {1'b0, y} + {{(CHANNEL_BITS+1){1'b0}}, y[2*CHANNEL_BITS-1:CHANNEL_BITS]}
          + {{(2*CHANNEL_BITS){1'b0}}, 1'b1};
    return sum[2*CHANNEL_BITS-1:CHANNEL_BITS];
  endfunction

endpackage

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
// Top level of the pipelined HSV to RGB pixel converter.
//
// Usage: drive an HSV pixel on in_data and raise start for one cycle; the
// transaction is accepted at that clock edge, since busy is always low. A
// new transaction may be started in every cycle, so the block sustains one
// pixel per clock.
// Each transaction yields exactly one RGB result. It appears on out_data for
// one cycle, marked by out_valid, after the three register stages (stage 1:
// sector and 1 - s*f terms, stage 2: the three v products, stage 3:
// division by the full-scale value and the sector permutation).
// The receiver cannot stall; it must take each result in the cycle it is
// shown. The three register stages set the latency, and the throughput is
// one transaction per cycle.
// Reset (rst_n low, synchronous) drops every transaction still in the
// pipeline; no result is delivered for them. The converter holds no other
// state.
module hsv_to_rgb_converter_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  hsv2rgb_pkg::hsv_in_t  in_data,
  output logic                  out_valid,
  output hsv2rgb_pkg::rgb_out_t out_data
);
  import hsv2rgb_pkg::*;

  localparam int PW = SCALE_BITS;            // width of the scaled 1 - s*f terms
  localparam int QW = CHANNEL_BITS + PW;     // width of v times a scaled term

  // The pipeline never backs up, so a transaction is accepted every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Stage 1: reduce the hue sector modulo six and form the saturation terms.
  // ---------------------------------------------------------------------
  logic [2:0]           hue_sec;
  logic [2:0]           sec_mod;
  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS:0]   frac_inv;
  logic [PW-1:0]        s_f;
  logic [PW-1:0]        s_finv;

  logic                 valid1_r;
  sector_t              sec1_r,   sec1_nxt;
  chan_t                v1_r;
  chan_t                sinv1_r,  sinv1_nxt;
  logic [PW-1:0]        nq1_r,    nq1_nxt;
  logic [PW-1:0]        nt1_r,    nt1_nxt;

  always_comb begin
    hue_sec  = in_data.hue[HUE_BITS-1:FRAC_BITS];
    // Hues past the last sector wrap around to the first ones.
    sec_mod  = (hue_sec > 3'd5) ? (hue_sec - 3'd6) : hue_sec;
    sec1_nxt = sector_t'(sec_mod);
    frac     = in_data.hue[FRAC_BITS-1:0];
    frac_inv = FRAC_ONE - {1'b0, frac};
    s_f      = PW'(in_data.saturation) * PW'(frac);
    s_finv   = PW'(in_data.saturation) * PW'(frac_inv);
    sinv1_nxt = CH_MAX - in_data.saturation;
    nq1_nxt   = K_SCALE - s_f;
    nt1_nxt   = K_SCALE - s_finv;
  end

  // ---------------------------------------------------------------------
  // Stage 2: scale the three terms by the brightness.
  // ---------------------------------------------------------------------
  logic                      valid2_r;
  sector_t                   sec2_r;
  chan_t                     v2_r;
  logic [2*CHANNEL_BITS-1:0] pp2_r, pp2_nxt;
  logic [QW-1:0]             pq2_r, pq2_nxt;
  logic [QW-1:0]             pt2_r, pt2_nxt;

  always_comb begin
    pp2_nxt = (2*CHANNEL_BITS)'(v1_r) * (2*CHANNEL_BITS)'(sinv1_r);
    pq2_nxt = QW'(v1_r) * QW'(nq1_r);
    pt2_nxt = QW'(v1_r) * QW'(nt1_r);
  end

  // ---------------------------------------------------------------------
  // Stage 3: divide by the full-scale value and pick the sector order.
  // Dividing by CH_MAX * 2^FRAC_BITS is a shift followed by a division
  // by CH_MAX.
  // ---------------------------------------------------------------------
  chan_t    p_val, q_val, t_val;
  rgb_out_t out_nxt;
  logic     out_valid_r;
  rgb_out_t out_data_r;

  always_comb begin
    p_val = div_by_max(pp2_r);
    q_val = div_by_max(pq2_r[QW-1:FRAC_BITS]);
    t_val = div_by_max(pt2_r[QW-1:FRAC_BITS]);
    case (sec2_r)
      SEC_RED_RISE_G:   out_nxt = '{red: v2_r,  green: t_val, blue: p_val};
      SEC_GREEN_FALL_R: out_nxt = '{red: q_val, green: v2_r,  blue: p_val};
      SEC_GREEN_RISE_B: out_nxt = '{red: p_val, green: v2_r,  blue: t_val};
      SEC_BLUE_FALL_G:  out_nxt = '{red: p_val, green: q_val, blue: v2_r};
      SEC_BLUE_RISE_R:  out_nxt = '{red: t_val, green: p_val, blue: v2_r};
      default:          out_nxt = '{red: v2_r,  green: p_val, blue: q_val};
    endcase
  end

  // Valid bits travel alongside the data and are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      valid2_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid1_r    <= accept;
      valid2_r    <= valid1_r;
      out_valid_r <= valid2_r;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    sec1_r     <= sec1_nxt;
    v1_r       <= in_data.brightness;
    sinv1_r    <= sinv1_nxt;
    nq1_r      <= nq1_nxt;
    nt1_r      <= nt1_nxt;
    sec2_r     <= sec1_r;
    v2_r       <= v1_r;
    pp2_r      <= pp2_nxt;
    pq2_r      <= pq2_nxt;
    pt2_r      <= pt2_nxt;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Every transaction in stage 2 shows up as exactly one result.
  a_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
    valid2_r |=> out_valid)
    else $error("stage 2 transaction did not produce a result");

  // No result appears without a transaction behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !valid2_r |=> !out_valid)
    else $error("result strobe without a transaction");

  // Zero saturation gives grey at the brightness value on the output.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (valid1_r && sinv1_r == CH_MAX) |-> ##2
      (out_data.red == $past(v1_r, 2) && out_data.green == $past(v1_r, 2) &&
       out_data.blue == $past(v1_r, 2)))
    else $error("zero saturation did not give grey");

endmodule
